FILE: sv/apq_pkg.sv
// ----------------------------------------------------------------------------
// apq_pkg
// Shared codes and types for the ascending priority queue.
// ----------------------------------------------------------------------------
package apq_pkg;

  // Width of the count field in a result transaction
  localparam int unsigned COUNT_W = 4;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_DELETE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_e;

  // Per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic ins;  // insert the broadcast value
    logic del;  // shift every entry one place toward the head
  } cell_ctrl_t;

endpackage

FILE: sv/apq_cell.sv
// ----------------------------------------------------------------------------
// apq_cell
// One slot of the sorted chain: holds an entry, compares it against the
// broadcast value and takes its own, its left or its right neighbor's data, or the broadcast value.
// ----------------------------------------------------------------------------
module apq_cell
  import apq_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 16,
  parameter int unsigned CNT_W       = 4,
  parameter int unsigned INDEX       = 0
) (
  input  logic                   clk_i,
  input  cell_ctrl_t             ctrl_i,
  input  logic [VALUE_WIDTH-1:0] value_i,
  input  logic [CNT_W-1:0]       count_i,
  input  logic [VALUE_WIDTH-1:0] left_entry_i,
  input  logic                   left_gt_i,
  input  logic [VALUE_WIDTH-1:0] right_entry_i,
  output logic [VALUE_WIDTH-1:0] entry_o,
  output logic                   gt_o
);

  logic [VALUE_WIDTH-1:0] entry_q, entry_d;
  logic                   occupied;

  assign occupied = count_i > CNT_W'(INDEX);
  // An empty slot counts as greater so the new value lands at the tail
  assign gt_o     = occupied ? ($signed(entry_q) > $signed(value_i)) : 1'b1;
  assign entry_o  = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (left_gt_i) begin
        entry_d = left_entry_i;
      end else if (gt_o) begin
        entry_d = value_i;
      end
    end else if (ctrl_i.del) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

FILE: sv/ascending_priority_queue.sv
// Ascending priority queue. Holds up to CAPACITY signed values in a chain of
// cells kept in ascending order. An insert transaction (tuser = 0) places the
// value behind every stored entry less than or equal to it; a delete
// transaction (tuser = 1) removes and returns the smallest entry. Every
// transaction yields one result: removed value (zero unless a delete
// succeeded), a status code (ok, overflow, empty) and the entry count after
// the command. Each cell compares its entry against the broadcast value in
// the same cycle and shifts or loads, and commands are accepted every cycle
// while results are taken; the result is registered at the output. The next
// command may enter in the cycle the waiting result is taken, but a result
// held by a stalled receiver holds the input off until that result
// transaction completes.
// ----------------------------------------------------------------------------
// ascending_priority_queue
// Sorted chain of cells with a count register and a registered result.
// ----------------------------------------------------------------------------
module ascending_priority_queue
  import apq_pkg::*;
#(
  parameter int unsigned CAPACITY    = 8,
  parameter int unsigned VALUE_WIDTH = 16,
  localparam int unsigned IN_W       = ((VALUE_WIDTH + 7) / 8) * 8,
  localparam int unsigned OUT_RAW_W  = VALUE_WIDTH + 2 + COUNT_W,
  localparam int unsigned OUT_W      = ((OUT_RAW_W + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [IN_W-1:0]  s_axis_tdata_i,   // new_value
  input  logic             s_axis_tuser_i,   // command
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [OUT_W-1:0] m_axis_tdata_o    // removed_value, status, count_after
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]       count_q, count_d;
  logic                   out_valid_q;
  logic [OUT_RAW_W-1:0]   out_data_q, out_data_d;
  logic                   accept, full, empty;
  logic [VALUE_WIDTH-1:0] value;
  cell_ctrl_t             ctrl;
  status_e                status;
  logic [VALUE_WIDTH-1:0] removed;
  logic [CNT_W+COUNT_W-1:0] count_ext;

  logic [VALUE_WIDTH-1:0] entry [CAPACITY];
  logic [CAPACITY-1:0]    gt;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign value           = s_axis_tdata_i[VALUE_WIDTH-1:0];
  assign full            = count_q == CNT_W'(CAPACITY);
  assign empty           = count_q == '0;

  always_comb begin
    ctrl    = '0;
    count_d = count_q;
    status  = ST_OK;
    removed = '0;
    if (s_axis_tuser_i == CMD_INSERT) begin
      if (full) begin
        status = ST_OVERFLOW;
      end else begin
        ctrl.ins = accept;
        count_d  = count_q + 1'b1;
      end
    end else begin
      if (empty) begin
        status = ST_EMPTY;
      end else begin
        ctrl.del = accept;
        count_d  = count_q - 1'b1;
        removed  = entry[0];
      end
    end
    count_ext  = {{COUNT_W{1'b0}}, count_d};
    out_data_d = {count_ext[COUNT_W-1:0], status, removed};
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] left_entry, right_entry;
    logic                   left_gt;

    if (i == 0) begin : g_head
      assign left_entry = value;
      assign left_gt    = 1'b0;
    end else begin : g_body
      assign left_entry = entry[i-1];
      assign left_gt    = gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_entry = entry[i];
    end else begin : g_inner
      assign right_entry = entry[i+1];
    end

    apq_cell #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .CNT_W       (CNT_W),
      .INDEX       (i)
    ) u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .value_i       (value),
      .count_i       (count_q),
      .left_entry_i  (left_entry),
      .left_gt_i     (left_gt),
      .right_entry_i (right_entry),
      .entry_o       (entry[i]),
      .gt_o          (gt[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the result until the downstream transaction completes
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_W'(out_data_q);

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(count_q))
    else $error("entry count changed without a transaction");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && s_axis_tuser_i == CMD_DELETE && empty |=>
      out_data_q[VALUE_WIDTH +: 2] == ST_EMPTY && count_q == '0 &&
      out_data_q[VALUE_WIDTH-1:0] == '0)
    else $error("empty delete result malformed");

  a_overflow_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && s_axis_tuser_i == CMD_INSERT && full |=>
      count_q == CNT_W'(CAPACITY) && out_data_q[VALUE_WIDTH +: 2] == ST_OVERFLOW)
    else $error("overflow insert changed the queue");
`endif

endmodule
